FILE: rtl/core/lkv_pkg.sv
// shared types and constants for the lru key-value cache
package lkv_pkg;

   localparam int KEY_W  = 32;
   localparam int DATA_W = 32;
   localparam int CAP_W  = 5;

   localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
   localparam logic [DATA_W-1:0] MISS_VALUE = '1;
   localparam logic [DATA_W-1:0] PUT_VALUE  = '0;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } op_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] data;
   } kv_entry_type;

endpackage

FILE: rtl/core/lkv_store.sv
// key/data memory and age memory, one write and one registered read each
module lkv_store
   import lkv_pkg::*;
#(
   parameter int ENTRIES = 16,
   parameter int AW      = 4
) (
   input  logic         clock,
   input  logic         rd_en,
   input  logic [AW-1:0] rd_addr,
   output kv_entry_type rd_kv,
   output logic [AW-1:0] rd_age,
   input  logic         kv_we,
   input  logic [AW-1:0] kv_waddr,
   input  kv_entry_type kv_wdata,
   input  logic         age_we,
   input  logic [AW-1:0] age_waddr,
   input  logic [AW-1:0] age_wdata
);

   kv_entry_type  kv_mem [ENTRIES];
   logic [AW-1:0] age_mem [ENTRIES];

   kv_entry_type  rd_kv_ff;
   logic [AW-1:0] rd_age_ff;

   always_ff @(posedge clock) begin
      if (kv_we) begin
         kv_mem[kv_waddr] <= kv_wdata;
      end
      if (rd_en) begin
         rd_kv_ff <= kv_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (age_we) begin
         age_mem[age_waddr] <= age_wdata;
      end
      if (rd_en) begin
         rd_age_ff <= age_mem[rd_addr];
      end
   end

   assign rd_kv  = rd_kv_ff;
   assign rd_age = rd_age_ff;

endmodule

FILE: rtl/core/lkv_ctrl.sv
// sequencer: scans the entries, applies the last touch lazily, decides and answers
module lkv_ctrl
   import lkv_pkg::*;
#(
   parameter int ENTRIES = 16,
   parameter int AW      = 4,
   parameter int OW      = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [OW-1:0]            cap_eff,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_opcode,
   input  logic signed [KEY_W-1:0]  req_lookup_key,
   input  logic signed [DATA_W-1:0] req_write_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_hit,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic                     rd_en,
   output logic [AW-1:0]            rd_addr,
   input  kv_entry_type             rd_kv,
   input  logic [AW-1:0]            rd_age,
   output logic                     kv_we,
   output logic [AW-1:0]            kv_waddr,
   output kv_entry_type             kv_wdata,
   output logic                     age_we,
   output logic [AW-1:0]            age_waddr,
   output logic [AW-1:0]            age_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

   state_type           state_ff;
   op_type              op_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [DATA_W-1:0]   wval_ff;
   logic [AW-1:0]       rd_idx_ff;
   logic                p1_valid_ff;
   logic [AW-1:0]       p1_idx_ff;
   logic [ENTRIES-1:0]  valid_ff;
   logic [OW-1:0]       occ_ff;
   logic                pend_valid_ff;
   logic [AW-1:0]       pend_age_ff;
   logic [AW-1:0]       pend_slot_ff;
   logic                hit_found_ff;
   logic [AW-1:0]       hit_slot_ff;
   logic [AW-1:0]       hit_age_ff;
   logic [DATA_W-1:0]   hit_data_ff;
   logic                vic_found_ff;
   logic [AW-1:0]       vic_slot_ff;
   logic [AW-1:0]       vic_age_ff;
   logic                free_found_ff;
   logic [AW-1:0]       free_slot_ff;
   logic                rsp_valid_ff;
   logic                rsp_hit_ff;
   logic [DATA_W-1:0]   rsp_data_ff;

   logic              accept;
   logic              fire;
   logic [AW-1:0]     cur_age;
   logic              ent_valid;
   logic              ent_hit;
   logic              evict;
   logic              pend_set;
   logic [AW-1:0]     pend_age_new;
   logic [AW-1:0]     pend_slot_new;
   logic              set_valid;
   logic              out_hit;
   logic [DATA_W-1:0] out_data;
   logic              wr_kv;
   logic [AW-1:0]     wr_slot;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign fire      = (state_ff == ST_DECIDE) && (!rsp_valid_ff || !rsp_stall);

   assign rd_en   = (state_ff == ST_SCAN);
   assign rd_addr = rd_idx_ff;

   // bring the stored age up to date with the previous item's touch
   always_comb begin
      if (pend_valid_ff && p1_idx_ff == pend_slot_ff) begin
         cur_age = '0;
      end else if (pend_valid_ff && rd_age < pend_age_ff) begin
         cur_age = rd_age + AW'(1);
      end else begin
         cur_age = rd_age;
      end
   end

   assign ent_valid = valid_ff[p1_idx_ff];
   assign ent_hit   = ent_valid && (rd_kv.key == key_ff);

   assign age_we    = p1_valid_ff;
   assign age_waddr = p1_idx_ff;
   assign age_wdata = cur_age;

   // cap_eff never exceeds the entry count, so this also covers a full store
   assign evict = (occ_ff >= cap_eff);

   always_comb begin
      pend_set      = 1'b0;
      pend_age_new  = hit_age_ff;
      pend_slot_new = hit_slot_ff;
      set_valid     = 1'b0;
      wr_kv         = 1'b0;
      wr_slot       = hit_slot_ff;
      out_hit       = hit_found_ff;
      out_data      = PUT_VALUE;
      unique case (op_ff)
         OP_GET: begin
            pend_set = hit_found_ff;
            out_data = hit_found_ff ? hit_data_ff : MISS_VALUE;
         end
         OP_PUT: begin
            priority if (hit_found_ff) begin
               pend_set = 1'b1;
               wr_kv    = 1'b1;
            end else if (evict && vic_found_ff) begin
               pend_set      = 1'b1;
               pend_age_new  = vic_age_ff;
               pend_slot_new = vic_slot_ff;
               wr_kv         = 1'b1;
               wr_slot       = vic_slot_ff;
            end else if (free_found_ff) begin
               // new entry: every valid entry grows older
               pend_set      = 1'b1;
               pend_age_new  = AW'(occ_ff);
               pend_slot_new = free_slot_ff;
               set_valid     = 1'b1;
               wr_kv         = 1'b1;
               wr_slot       = free_slot_ff;
            end else begin
               pend_set = 1'b0;
            end
         end
         default: begin
            pend_set = 1'b0;
         end
      endcase
   end

   assign kv_we         = fire && wr_kv;
   assign kv_waddr      = wr_slot;
   assign kv_wdata.key  = key_ff;
   assign kv_wdata.data = wval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_idx_ff     <= '0;
         p1_valid_ff   <= 1'b0;
         valid_ff      <= '0;
         occ_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hit_found_ff  <= 1'b0;
         vic_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         p1_valid_ff <= (state_ff == ST_SCAN);
         p1_idx_ff   <= rd_idx_ff;

         if (fire) begin
            rsp_valid_ff <= 1'b1;
            rsp_hit_ff   <= out_hit;
            rsp_data_ff  <= out_data;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (p1_valid_ff) begin
            if (ent_hit) begin
               hit_found_ff <= 1'b1;
               hit_slot_ff  <= p1_idx_ff;
               hit_age_ff   <= cur_age;
               hit_data_ff  <= rd_kv.data;
            end
            if (ent_valid && (!vic_found_ff || cur_age > vic_age_ff)) begin
               vic_found_ff <= 1'b1;
               vic_slot_ff  <= p1_idx_ff;
               vic_age_ff   <= cur_age;
            end
            if (!ent_valid && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_slot_ff  <= p1_idx_ff;
            end
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_ff         <= op_type'(req_opcode);
                  key_ff        <= req_lookup_key;
                  wval_ff       <= req_write_value;
                  rd_idx_ff     <= '0;
                  hit_found_ff  <= 1'b0;
                  vic_found_ff  <= 1'b0;
                  free_found_ff <= 1'b0;
                  state_ff      <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               rd_idx_ff <= rd_idx_ff + AW'(1);
               if (rd_idx_ff == AW'(ENTRIES - 1)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               if (fire) begin
                  pend_valid_ff <= pend_set;
                  pend_age_ff   <= pend_age_new;
                  pend_slot_ff  <= pend_slot_new;
                  if (set_valid) begin
                     valid_ff[wr_slot] <= 1'b1;
                     occ_ff            <= occ_ff + OW'(1);
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_data_ff;

endmodule

FILE: rtl/core/lru_key_value_cache.sv
// lru key-value cache: one get or put per item, every access a pass over the entry memories
// an accepted request scans every entry, drains the read, then decides when the response
//   register is free; no new request is taken until then, paced by the single read port of
//   the entry memories, read one entry per cycle while the previous touch is written back
// reset: valid bits, occupancy and pending touch clear at once, capacity returns to 16;
//   key, data and age memories are not cleared and need no clearing pass
module lru_key_value_cache
   import lkv_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CAP_W-1:0]         csr_wr_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_opcode,
   input  logic signed [KEY_W-1:0]  req_lookup_key,
   input  logic signed [DATA_W-1:0] req_write_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_hit,
   output logic signed [DATA_W-1:0] rsp_read_value
);

   localparam int AW = $clog2(ENTRIES);
   localparam int OW = $clog2(ENTRIES + 1);
   localparam int CW = (OW > CAP_W) ? OW : CAP_W;

   logic [CAP_W-1:0] capacity_ff;
   logic [CW-1:0]    cap_ext;
   logic [OW-1:0]    cap_eff;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   kv_entry_type  rd_kv;
   logic [AW-1:0] rd_age;
   logic          kv_we;
   logic [AW-1:0] kv_waddr;
   kv_entry_type  kv_wdata;
   logic          age_we;
   logic [AW-1:0] age_waddr;
   logic [AW-1:0] age_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   // zero counts as one, anything above the entry count saturates
   always_comb begin
      cap_ext = CW'(capacity_ff);
      if (capacity_ff == '0) begin
         cap_eff = OW'(1);
      end else if (cap_ext > CW'(ENTRIES)) begin
         cap_eff = OW'(ENTRIES);
      end else begin
         cap_eff = OW'(cap_ext);
      end
   end

   lkv_store #(
      .ENTRIES (ENTRIES),
      .AW      (AW)
   ) u_store (
      .clock     (clock),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_kv     (rd_kv),
      .rd_age    (rd_age),
      .kv_we     (kv_we),
      .kv_waddr  (kv_waddr),
      .kv_wdata  (kv_wdata),
      .age_we    (age_we),
      .age_waddr (age_waddr),
      .age_wdata (age_wdata)
   );

   lkv_ctrl #(
      .ENTRIES (ENTRIES),
      .AW      (AW),
      .OW      (OW)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .cap_eff         (cap_eff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_lookup_key  (req_lookup_key),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_kv           (rd_kv),
      .rd_age          (rd_age),
      .kv_we           (kv_we),
      .kv_waddr        (kv_waddr),
      .kv_wdata        (kv_wdata),
      .age_we          (age_we),
      .age_waddr       (age_waddr),
      .age_wdata       (age_wdata)
   );

endmodule
